@@ rtl/core/bba_pkg.sv @@
package bba_pkg;

    localparam int NUM_BLOCKS  = 16384;
    localparam int WORD_BITS   = 32;
    localparam int NUM_WORDS   = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int WIDX_W      = $clog2(NUM_WORDS);
    localparam int BLK_W       = 14;
    localparam int CNT_W       = 15;
    localparam int RESULT_SPAN = 16384;
    localparam int LIMIT_MAX   = (NUM_BLOCKS < RESULT_SPAN) ? NUM_BLOCKS : RESULT_SPAN;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic REG_FIRST_DATA_BLOCK = 1'b0;
    localparam logic REG_BLOCK_COUNT      = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [BLK_W-1:0] first_data_block;
        logic [CNT_W-1:0] block_count;
    } cfg_t;

    typedef struct packed {
        status_t          status;
        logic [BLK_W-1:0] block;
    } result_t;

    typedef struct packed {
        logic             use_lo;
        logic [BIT_W-1:0] lo;
        logic             use_hi;
        logic [BIT_W-1:0] hi;
    } ffz_range_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } ffz_res_t;

endpackage

@@ rtl/core/bba_ram.sv @@
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/bba_ffz.sv @@
module bba_ffz (
    input  logic [bba_pkg::WORD_BITS-1:0] word,
    input  bba_pkg::ffz_range_t           range,
    output bba_pkg::ffz_res_t             res
);

    always_comb
    begin
        res = '0;
        for (int b = bba_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            if (!word[b]
                && (!range.use_lo || (bba_pkg::BIT_W'(b) >= range.lo))
                && (!range.use_hi || (bba_pkg::BIT_W'(b) <= range.hi)))
            begin
                res.found = 1'b1;
                res.pos   = bba_pkg::BIT_W'(b);
            end
        end
    end

endmodule

@@ rtl/core/bba_ctrl.sv @@
module bba_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bba_pkg::cfg_t                       cfg,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                req_type,
    input  logic [bba_pkg::BLK_W-1:0]           req_block,
    output logic                                res_valid,
    input  logic                                res_ready,
    output bba_pkg::result_t                    res,
    output logic                                ram_we,
    output logic [bba_pkg::WIDX_W-1:0]          ram_waddr,
    output logic [bba_pkg::WORD_BITS-1:0]       ram_wdata,
    output logic [bba_pkg::WIDX_W-1:0]          ram_raddr,
    input  logic [bba_pkg::WORD_BITS-1:0]       ram_rdata
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_FREE  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [bba_pkg::WIDX_W-1:0]      word_reg, word_next;
    logic [bba_pkg::BIT_W-1:0]       blk_reg, blk_next;
    bba_pkg::result_t                res_reg, res_next;

    logic [bba_pkg::CNT_W-1:0]       lim;
    logic [bba_pkg::CNT_W-1:0]       lim_m1;
    logic [bba_pkg::WIDX_W-1:0]      first_word;
    logic [bba_pkg::WIDX_W-1:0]      last_word;
    logic                            start_past;
    logic                            id_past;
    bba_pkg::ffz_range_t             range;
    bba_pkg::ffz_res_t               hit;

    bba_ffz u_ffz (
        .word  (ram_rdata),
        .range (range),
        .res   (hit)
    );

    always_comb
    begin
        lim = (cfg.block_count > bba_pkg::CNT_W'(bba_pkg::LIMIT_MAX))
            ? bba_pkg::CNT_W'(bba_pkg::LIMIT_MAX) : cfg.block_count;
        lim_m1     = lim - bba_pkg::CNT_W'(1);
        first_word = bba_pkg::WIDX_W'(cfg.first_data_block >> bba_pkg::BIT_W);
        last_word  = bba_pkg::WIDX_W'(lim_m1 >> bba_pkg::BIT_W);
        start_past = {1'b0, cfg.first_data_block} >= lim;
        id_past    = {1'b0, req_block} >= lim;

        range.use_lo = (word_reg == first_word);
        range.lo     = cfg.first_data_block[bba_pkg::BIT_W-1:0];
        range.use_hi = (word_reg == last_word);
        range.hi     = lim_m1[bba_pkg::BIT_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        blk_next   = blk_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = word_reg;
        ram_wdata  = '0;
        ram_raddr  = word_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                word_next = word_reg + bba_pkg::WIDX_W'(1);
                if (word_reg == bba_pkg::WIDX_W'(bba_pkg::NUM_WORDS - 1))
                begin
                    word_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_type == bba_pkg::REQ_ALLOC)
                begin
                    ram_raddr = first_word;
                end
                else
                begin
                    ram_raddr = bba_pkg::WIDX_W'(req_block >> bba_pkg::BIT_W);
                end
                if (req_valid)
                begin
                    blk_next       = req_block[bba_pkg::BIT_W-1:0];
                    word_next      = ram_raddr;
                    res_next.block = '0;
                    if (req_type == bba_pkg::REQ_ALLOC)
                    begin
                        if (start_past)
                        begin
                            res_next.status = bba_pkg::STATUS_FULL;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        if (id_past)
                        begin
                            res_next.status = bba_pkg::STATUS_RANGE;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_FREE;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit.found)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = ram_rdata
                                    | (bba_pkg::WORD_BITS'(1) << hit.pos);
                    res_next.status = bba_pkg::STATUS_OK;
                    res_next.block  = bba_pkg::BLK_W'({word_reg, hit.pos});
                    state_next      = ST_DONE;
                end
                else if (word_reg == last_word)
                begin
                    res_next.status = bba_pkg::STATUS_FULL;
                    state_next      = ST_DONE;
                end
                else
                begin
                    word_next = word_reg + bba_pkg::WIDX_W'(1);
                    ram_raddr = word_next;
                end
            end
            ST_FREE:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(bba_pkg::WORD_BITS'(1) << blk_reg);
                res_next.status = bba_pkg::STATUS_OK;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                word_next  = '0;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        res_reg <= res_next;
    end

endmodule

@@ rtl/core/bitmap_block_allocator_unit.sv @@
// First-fit block allocator over a used-block bitmap held in on-chip RAM.
// Requests enter on the s_axis channel: tuser selects allocate (0) or free (1),
// and tdata carries the block to free. Each request yields one response on the
// m_axis channel: tuser holds the status and tdata the allocated block index.
// The APB port holds the first data block and the block count; write them only
// while no request is in flight.
// After reset the block sweeps all 512 words of the bitmap RAM, one word per
// cycle, clearing them; s_axis_tready stays low during that sweep.
// An allocate reads one 32-bit bitmap word per cycle through the single RAM
// read port and searches it with one find-first-clear unit. A free reads the
// word holding its block and writes it back with that bit cleared. A request
// refused at once, an allocate whose start lies at or past the limit or a free
// out of range, is answered without touching the bitmap.
// One request is handled at a time. The response sits in an output register,
// so the next request can be taken while the previous response is not yet
// taken; if that register is still full when a new response is ready, the
// block holds it and accepts nothing until m_axis_tready frees the register.
module bitmap_block_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [13:0] req_block, [15:14] zero
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [13:0] result_block, [15:14] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bba_pkg::cfg_t                    cfg_reg;
    bba_pkg::result_t                 res;
    bba_pkg::result_t                 out_reg;
    logic                             out_valid_reg;
    logic                             res_valid;
    logic                             res_ready;
    logic                             ram_we;
    logic [bba_pkg::WIDX_W-1:0]       ram_waddr;
    logic [bba_pkg::WORD_BITS-1:0]    ram_wdata;
    logic [bba_pkg::WIDX_W-1:0]       ram_raddr;
    logic [bba_pkg::WORD_BITS-1:0]    ram_rdata;
    logic                             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_data_block <= '0;
            cfg_reg.block_count      <= bba_pkg::CNT_W'(16384);
        end
        else if (cfg_write)
        begin
            if (paddr[2] == bba_pkg::REG_FIRST_DATA_BLOCK)
            begin
                cfg_reg.first_data_block <= pwdata[bba_pkg::BLK_W-1:0];
            end
            else
            begin
                cfg_reg.block_count <= pwdata[bba_pkg::CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == bba_pkg::REG_BLOCK_COUNT)
        begin
            prdata = 32'(cfg_reg.block_count);
        end
        else
        begin
            prdata = 32'(cfg_reg.first_data_block);
        end
    end

    bba_ram #(
        .WIDTH (bba_pkg::WORD_BITS),
        .DEPTH (bba_pkg::NUM_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req_type  (s_axis_tuser),
        .req_block (s_axis_tdata[bba_pkg::BLK_W-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 16'(out_reg.block);
    assign m_axis_tuser  = out_reg.status;

endmodule
